// ----- rtl/programmable_lfsr_period_keystream_core_macros.svh -----
// Assertion helpers shared by the keystream core files.
`ifndef PROGRAMMABLE_LFSR_PERIOD_KEYSTREAM_CORE_MACROS_SVH
`define PROGRAMMABLE_LFSR_PERIOD_KEYSTREAM_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PLKS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plks assertion failed");

// Next-cycle implication, disabled while in reset.
`define PLKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plks assertion failed");

`endif

// ----- rtl/plks_pkg.sv -----
`timescale 1ns / 1ps
package plks_pkg;

  localparam int MAX_STAGES = 32;
  localparam int KEY_BITS   = 8;
  localparam int STAGE_CAP  = (MAX_STAGES > 32) ? 32 : MAX_STAGES;

  localparam int LEN_W   = 6;
  localparam int STATE_W = 32;
  localparam int CNT_W   = 33;
  localparam int BYTE_W  = 8;
  localparam int CIDX_W  = 2;

  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(8);
  localparam logic [BYTE_W-1:0] KEY_MASK  = BYTE_W'((9'd1 << KEY_BITS) - 9'd1);

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_STEP    = 2'd1,
    OP_XOR     = 2'd2,
    OP_IDLE    = 2'd3
  } op_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LENGTH = 2'd0,
    CFG_TAPS   = 2'd1,
    CFG_SEED   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [STATE_W-1:0] taps;
    logic [STATE_W-1:0] seed;
  } cfg_t;

  typedef struct packed {
    logic               out_bit;
    logic [STATE_W-1:0] state_value;
    logic               period_known;
    logic [CNT_W-1:0]   period_length;
    logic               no_return;
    logic [BYTE_W-1:0]  key_value;
    logic [BYTE_W-1:0]  data_out;
  } result_t;

  // Clamp the programmed length to between 2 and the stages that exist.
  function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n < LEN_W'(2)) n = LEN_W'(2);
    if (n > LEN_W'(STAGE_CAP)) n = LEN_W'(STAGE_CAP);
    return n;
  endfunction

  function automatic logic [STATE_W-1:0] len_mask(input logic [LEN_W-1:0] n);
    logic [STATE_W:0] one_hot;
    one_hot = (STATE_W+1)'(1) << n;
    return STATE_W'(one_hot - (STATE_W+1)'(1));
  endfunction

endpackage

// ----- rtl/plks_key_gen.sv -----
`timescale 1ns / 1ps
module plks_key_gen import plks_pkg::*; (
  input  cfg_t               cfg_i,
  input  logic [LEN_W-1:0]   len_i,
  input  logic [STATE_W-1:0] mask_i,
  output logic [BYTE_W-1:0]  key_o
);

  logic [STATE_W-1:0] seed_m;
  logic [STATE_W-1:0] win;
  logic [BYTE_W-1:0]  key_long;
  logic [BYTE_W-1:0]  key_short;
  logic [BYTE_W-1:0]  m8;
  logic [BYTE_W-1:0]  tap8;
  logic [2:0]         top_idx;
  logic [BYTE_W-1:0]  s8 [0:BYTE_W];

  // Eight or more stages: the first eight outputs are seed bits read from the top down.
  always_comb begin
    seed_m = cfg_i.seed & mask_i;
    win    = seed_m >> (len_i - LEN_W'(8));
    for (int i = 0; i < BYTE_W; i++) begin
      key_long[i] = win[BYTE_W-1-i];
    end
  end

  // Short registers: run the feedback on the low byte only.
  always_comb begin
    m8      = mask_i[BYTE_W-1:0];
    tap8    = cfg_i.taps[BYTE_W-1:0];
    top_idx = 3'(len_i - LEN_W'(1));
    s8[0]   = cfg_i.seed[BYTE_W-1:0] & m8;
    for (int i = 0; i < BYTE_W; i++) begin
      key_short[i] = s8[i][top_idx];
      s8[i+1]      = {s8[i][BYTE_W-2:0], ^(s8[i] & tap8)} & m8;
    end
  end

  assign key_o = ((len_i >= LEN_W'(8)) ? key_long : key_short) & KEY_MASK;

endmodule

// ----- rtl/plks_datapath.sv -----
`timescale 1ns / 1ps
module plks_datapath import plks_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  op_e               op_i,
  input  logic [BYTE_W-1:0] data_i,
  input  cfg_t              cfg_i,
  output result_t           res_o
);
`include "programmable_lfsr_period_keystream_core_macros.svh"

  logic [STATE_W-1:0] state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               found_q, found_d;
  logic [CNT_W-1:0]   period_q, period_d;
  logic               over_q, over_d;
  logic [BYTE_W-1:0]  key_q, key_d;

  logic [LEN_W-1:0]   n;
  logic [STATE_W-1:0] m;
  logic [4:0]         last_idx;
  logic [STATE_W-1:0] cur;
  logic [STATE_W-1:0] seed_m;
  logic [STATE_W-1:0] stepped;
  logic [CNT_W-1:0]   cnt_inc;
  logic [BYTE_W-1:0]  key_new;
  logic               bit_out;
  logic [BYTE_W-1:0]  dout;

  assign n        = used_len(cfg_i.length);
  assign m        = len_mask(n);
  assign last_idx = 5'(n - LEN_W'(1));
  assign cur      = state_q & m;
  assign seed_m   = cfg_i.seed & m;
  assign stepped  = {cur[STATE_W-2:0], ^(cur & cfg_i.taps & m)} & m;
  assign cnt_inc  = cnt_q + CNT_W'(1);

  plks_key_gen u_key_gen (
    .cfg_i  (cfg_i),
    .len_i  (n),
    .mask_i (m),
    .key_o  (key_new)
  );

  always_comb begin
    state_d  = cur;
    cnt_d    = cnt_q;
    found_d  = found_q;
    period_d = period_q;
    over_d   = over_q;
    key_d    = key_q;
    bit_out  = cur[last_idx];
    dout     = '0;
    case (op_i)
      OP_RESTART: begin
        state_d  = seed_m;
        bit_out  = seed_m[last_idx];
        key_d    = key_new;
        cnt_d    = '0;
        found_d  = 1'b0;
        period_d = '0;
        over_d   = 1'b0;
      end
      OP_STEP: begin
        state_d = stepped;
        // Freeze the bookkeeping once the outcome is known.
        if (!found_q && !over_q) begin
          cnt_d = cnt_inc;
          if (stepped == seed_m) begin
            found_d  = 1'b1;
            period_d = cnt_inc;
          end else if ((cnt_inc >> n) != '0) begin
            over_d = 1'b1;
          end
        end
      end
      OP_XOR: begin
        dout = data_i ^ key_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      period_q <= '0;
      over_q   <= 1'b0;
      key_q    <= '0;
    end else if (fire_i) begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      period_q <= period_d;
      over_q   <= over_d;
      key_q    <= key_d;
    end
  end

  always_comb begin
    res_o.out_bit       = bit_out;
    res_o.state_value   = state_d;
    res_o.period_known  = found_d;
    res_o.period_length = period_d;
    res_o.no_return     = over_d;
    res_o.key_value     = key_d;
    res_o.data_out      = dout;
  end

  `PLKS_ASSERT_NOW(a_outcome_exclusive, clk_i, rst_ni, 1'b1, !(found_q && over_q))
  `PLKS_ASSERT_NEXT(a_restart_clears, clk_i, rst_ni, fire_i && op_i == OP_RESTART,
                    cnt_q == '0 && !found_q && !over_q)
  `PLKS_ASSERT_NEXT(a_count_frozen, clk_i, rst_ni,
                    (found_q || over_q) && !(fire_i && op_i == OP_RESTART), $stable(cnt_q))

endmodule

// ----- rtl/programmable_lfsr_period_keystream_core.sv -----
`timescale 1ns / 1ps
// An accepted transaction waits in the input register and passes through the datapath
// into the result register. Throughput: one transaction per cycle unless the output stalls;
// restart, step and xor all finish in one pass through the datapath between the two.
// Reset: asynchronous, active low; clears the stages, counters, flags and key,
// and loads length 8, tap mask 0 and seed 0. No clearing pass is needed.
module programmable_lfsr_period_keystream_core import plks_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CIDX_W-1:0]   cfg_index_i,
  input  logic [STATE_W-1:0]  cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [BYTE_W-1:0]   data_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_bit_o,
  output logic [STATE_W-1:0]  state_value_o,
  output logic                period_known_o,
  output logic [CNT_W-1:0]    period_length_o,
  output logic                no_return_o,
  output logic [BYTE_W-1:0]   key_value_o,
  output logic [BYTE_W-1:0]   data_out_o
);
`include "programmable_lfsr_period_keystream_core_macros.svh"

  cfg_t              cfg_q;
  logic              in_valid_q;
  op_e               op_q;
  logic [BYTE_W-1:0] data_q;
  logic              out_valid_q;
  result_t           res_q;
  result_t           res;
  logic              out_free;
  logic              fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length <= LEN_RESET;
      cfg_q.taps   <= '0;
      cfg_q.seed   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LENGTH: cfg_q.length <= cfg_data_i[LEN_W-1:0];
        CFG_TAPS:   cfg_q.taps   <= cfg_data_i;
        CFG_SEED:   cfg_q.seed   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || fire;

  // Input register: hold the transaction until the result register can take it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_e'(opcode_i);
      data_q <= data_in_i;
    end
  end

  plks_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (op_q),
    .data_i (data_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_bit_o       = res_q.out_bit;
  assign state_value_o   = res_q.state_value;
  assign period_known_o  = res_q.period_known;
  assign period_length_o = res_q.period_length;
  assign no_return_o     = res_q.no_return;
  assign key_value_o     = res_q.key_value;
  assign data_out_o      = res_q.data_out;

  `PLKS_ASSERT_NEXT(a_fire_fills_output, clk_i, rst_ni, fire, out_valid_q)
  `PLKS_ASSERT_NEXT(a_stalled_input_holds, clk_i, rst_ni, in_valid_q && !out_free,
                    in_valid_q && $stable(op_q) && $stable(data_q))
  `PLKS_ASSERT_NOW(a_ready_only_with_room, clk_i, rst_ni, in_ready_o && in_valid_q,
                   out_free)

endmodule

// ----- sim/programmable_lfsr_period_keystream_core_tb.sv -----
`timescale 1ns / 1ps
module programmable_lfsr_period_keystream_core_tb;
  import plks_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CIDX_W-1:0]   cfg_index_i;
  logic [STATE_W-1:0]  cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          opcode_i;
  logic [BYTE_W-1:0]   data_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                out_bit_o;
  logic [STATE_W-1:0]  state_value_o;
  logic                period_known_o;
  logic [CNT_W-1:0]    period_length_o;
  logic                no_return_o;
  logic [BYTE_W-1:0]   key_value_o;
  logic [BYTE_W-1:0]   data_out_o;

  programmable_lfsr_period_keystream_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .data_in_i       (data_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_bit_o       (out_bit_o),
    .state_value_o   (state_value_o),
    .period_known_o  (period_known_o),
    .period_length_o (period_length_o),
    .no_return_o     (no_return_o),
    .key_value_o     (key_value_o),
    .data_out_o      (data_out_o)
  );

  // Shadow copy of the configuration and the keystream state
  logic [LEN_W-1:0]   sh_len;
  logic [STATE_W-1:0] sh_taps;
  logic [STATE_W-1:0] sh_seed;
  logic [STATE_W-1:0] sh_stages;
  logic [CNT_W-1:0]   sh_steps;
  logic [CNT_W-1:0]   sh_period;
  logic               sh_found;
  logic               sh_overrun;
  logic [BYTE_W-1:0]  sh_key;

  result_t     keystream_due[$];
  int unsigned stall_pct;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned stages_in_use();
    int unsigned n;
    n = sh_len;
    if (n < 2) n = 2;
    if (n > STAGE_CAP) n = STAGE_CAP;
    return n;
  endfunction

  function automatic logic [STATE_W-1:0] stage_mask(int unsigned n);
    logic [STATE_W:0] w;
    w = ({{STATE_W{1'b0}}, 1'b1} << n) - 1;
    return w[STATE_W-1:0];
  endfunction

  function automatic logic [STATE_W-1:0] shift_once(logic [STATE_W-1:0] s, int unsigned n);
    logic fb;
    fb = ^(s & sh_taps & stage_mask(n));
    return ((s << 1) | {{(STATE_W-1){1'b0}}, fb}) & stage_mask(n);
  endfunction

  // Advance the shadow state by one transaction and return what the core must give back
  function automatic result_t keystream_result(op_e op, logic [BYTE_W-1:0] d);
    int unsigned n;
    logic [STATE_W-1:0] m;
    logic [STATE_W-1:0] s;
    logic [CNT_W:0]     bound;
    result_t r;
    n = stages_in_use();
    m = stage_mask(n);
    r = '0;
    sh_stages = sh_stages & m;
    r.out_bit = sh_stages[n-1];
    case (op)
      OP_RESTART: begin
        s = sh_seed & m;
        sh_stages = s;
        r.out_bit = s[n-1];
        sh_key = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
          sh_key[i] = s[n-1];
          s = shift_once(s, n);
        end
        sh_steps = '0;
        sh_period = '0;
        sh_found = 1'b0;
        sh_overrun = 1'b0;
      end
      OP_STEP: begin
        sh_stages = shift_once(sh_stages, n);
        if (!sh_found && !sh_overrun) begin
          sh_steps = sh_steps + 1'b1;
          bound = {{CNT_W{1'b0}}, 1'b1} << n;
          if (sh_stages == (sh_seed & m)) begin
            sh_found = 1'b1;
            sh_period = sh_steps;
          end else if ({1'b0, sh_steps} >= bound) begin
            sh_overrun = 1'b1;
          end
        end
      end
      OP_XOR: r.data_out = d ^ sh_key;
      default: ;
    endcase
    r.state_value = sh_stages;
    r.period_known = sh_found;
    r.period_length = sh_period;
    r.no_return = sh_overrun;
    r.key_value = sh_key;
    return r;
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: random back-pressure, compare every transaction with the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_t want;
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (keystream_due.size() == 0) begin
        $display("%0t: result with nothing expected, state 0x%0h", $time, state_value_o);
        mismatch_count++;
      end else begin
        want = keystream_due.pop_front();
        check_field("out_bit", CNT_W'(want.out_bit), CNT_W'(out_bit_o));
        check_field("state_value", CNT_W'(want.state_value), CNT_W'(state_value_o));
        check_field("period_known", CNT_W'(want.period_known), CNT_W'(period_known_o));
        check_field("period_length", want.period_length, period_length_o);
        check_field("no_return", CNT_W'(want.no_return), CNT_W'(no_return_o));
        check_field("key_value", CNT_W'(want.key_value), CNT_W'(key_value_o));
        check_field("data_out", CNT_W'(want.data_out), CNT_W'(data_out_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(op_e op, logic [BYTE_W-1:0] d);
    if ($urandom_range(99) < stall_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < stall_pct);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    data_in_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    keystream_due.push_back(keystream_result(op, d));
  endtask

  // Hold off the sender until every result is back, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (keystream_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [STATE_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_LENGTH: sh_len = value[LEN_W-1:0];
      CFG_TAPS:   sh_taps = value;
      CFG_SEED:   sh_seed = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [STATE_W-1:0] len, logic [STATE_W-1:0] taps,
                            logic [STATE_W-1:0] seed);
    wait_drained();
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_TAPS, taps);
    write_reg(CFG_SEED, seed);
  endtask

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return OP_STEP;
    if (r < 85) return OP_XOR;
    if (r < 94) return OP_RESTART;
    return OP_IDLE;
  endfunction

  // Short lengths dominate so that periods and overruns turn up often
  task automatic random_config();
    logic [STATE_W-1:0] len;
    logic [STATE_W-1:0] taps;
    logic [STATE_W-1:0] seed;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) len = $urandom_range(2, 8);
    else if (r < 90) len = $urandom_range(9, 32);
    else len = ($urandom & ~32'h3f) | $urandom_range(0, 63);
    taps = ($urandom_range(4) == 0) ? '0 : $urandom;
    seed = ($urandom_range(9) == 0) ? '0 : $urandom;
    set_config(len, taps, seed);
  endtask

  task automatic random_phases(int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      random_config();
      if ($urandom_range(9) != 0) begin
        send_item(OP_RESTART, BYTE_W'($urandom));
        sent++;
      end
      repeat ($urandom_range(20, 80)) begin
        send_item(pick_op(), BYTE_W'($urandom));
        sent++;
      end
    end
  endtask

  // Stepping and ciphering straight out of reset, plus the idle opcode
  task automatic test_reset_state();
    send_item(OP_STEP, 8'h00);
    send_item(OP_XOR, 8'hff);
    send_item(OP_IDLE, 8'haa);
  endtask

  // No taps: the register empties and never returns to a non-zero seed
  task automatic test_overrun();
    set_config(32'd2, 32'h0, 32'h2);
    send_item(OP_RESTART, 8'hff);
    repeat (5) send_item(OP_STEP, 8'h55);
  endtask

  // Register shorter than the key: key bits run on through the feedback
  task automatic test_short_key();
    set_config(32'd4, 32'h0000_000c, 32'h1);
    send_item(OP_RESTART, 8'h00);
    send_item(OP_XOR, 8'h00);
    send_item(OP_XOR, 8'hff);
  endtask

  // Over-range length saturates to the full register
  task automatic test_full_length();
    set_config(32'd63, 32'h8020_0003, 32'hffff_ffff);
    send_item(OP_RESTART, 8'h81);
    send_item(OP_STEP, 8'h7e);
    send_item(OP_STEP, 8'hff);
  endtask

  // Seed moved under a running sequence; bits above the length must be dropped
  task automatic test_seed_change();
    set_config(32'd0, 32'hffff_ffff, 32'h1);
    send_item(OP_RESTART, 8'h0f);
    send_item(OP_STEP, 8'hf0);
    wait_drained();
    write_reg(CFG_SEED, 32'hffff_fff2);
    send_item(OP_STEP, 8'h00);
    send_item(OP_STEP, 8'hff);
  endtask

  task automatic test_unused_index();
    wait_drained();
    write_reg(CFG_NONE, $urandom);
    send_item(OP_STEP, 8'h01);
  endtask

  // All-zero seed with no taps: period of one
  task automatic test_zero_seed();
    set_config(32'd8, 32'h0, 32'h0);
    send_item(OP_RESTART, 8'h80);
    send_item(OP_STEP, 8'h01);
  endtask

  task automatic test_back_to_back();
    stall_pct = 0;
    random_phases(200);
    wait_drained();
    stall_pct = 34;
  endtask

  task automatic test_pause_for_results();
    random_config();
    send_item(OP_RESTART, BYTE_W'($urandom));
    repeat (40) send_item(pick_op(), BYTE_W'($urandom));
    wait_drained();
    repeat (40) send_item(pick_op(), BYTE_W'($urandom));
  endtask

  initial begin
    stall_pct = 34;
    mismatch_count = 0;
    quiet_cycles = 0;
    sh_len = LEN_RESET;
    sh_taps = '0;
    sh_seed = '0;
    sh_stages = '0;
    sh_steps = '0;
    sh_period = '0;
    sh_found = 1'b0;
    sh_overrun = 1'b0;
    sh_key = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_LENGTH;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    opcode_i <= OP_IDLE;
    data_in_i <= '0;
    out_ready_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_overrun();
    test_short_key();
    test_full_length();
    test_seed_change();
    test_unused_index();
    test_zero_seed();
    test_back_to_back();
    test_pause_for_results();
    random_phases(1200);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
